/* hw/rtl/nwc_pkg.sv */
//------------------------------------------------------------------------------
// nwc_pkg
// Shared types and constants of the normalized window convolution block.
//------------------------------------------------------------------------------
package nwc_pkg;

	localparam int PIX_W  = 8;
	localparam int POS_W  = 12;
	localparam int GEOM_W = 13;
	localparam int CFG_W  = 24;
	localparam int IDX_W  = 3;
	localparam int NORM_W = 11;
	localparam int SUM_W  = 20;
	localparam int QUO_W  = 8;

	typedef enum logic [IDX_W-1:0] {
		REG_LINE_WIDTH   = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_COEF_TOP     = 3'd2,
		REG_COEF_MIDDLE  = 3'd3,
		REG_COEF_BOTTOM  = 3'd4
	} reg_index_t;

	typedef struct packed {
		logic             last;
		logic [POS_W-1:0] row;
		logic [POS_W-1:0] col;
	} res_tag_t;

endpackage

/* hw/rtl/nwc_divider.sv */
//------------------------------------------------------------------------------
// nwc_divider
// Pipelined restoring divider: one quotient bit per stage, eight stages.
//------------------------------------------------------------------------------
module nwc_divider
	import nwc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [SUM_W-1:0]  dividend,
	input  logic [NORM_W-1:0] divisor,
	input  res_tag_t          in_tag,
	input  logic              advance,
	output logic              out_valid,
	output logic [QUO_W-1:0]  quotient,
	output res_tag_t          out_tag
);

	// The quotient is known to fit in eight bits, so only the low eight
	// quotient positions are resolved; the remainder stays below the divisor.
	logic              vld_q [QUO_W+1];
	logic [SUM_W-1:0]  rem_q [QUO_W+1];
	logic [NORM_W-1:0] dvs_q [QUO_W+1];
	logic [QUO_W-1:0]  quo_q [QUO_W+1];
	res_tag_t          tag_q [QUO_W+1];

	always_comb begin
		vld_q[0] = in_valid;
		rem_q[0] = dividend;
		dvs_q[0] = divisor;
		quo_q[0] = '0;
		tag_q[0] = in_tag;
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_stage
		localparam int SH = QUO_W - 1 - k;
		logic [SUM_W:0] trial;
		logic           fits;
		logic              vld_s;
		logic [SUM_W-1:0]  rem_s;
		logic [NORM_W-1:0] dvs_s;
		logic [QUO_W-1:0]  quo_s;
		res_tag_t          tag_s;
		always_comb begin
			trial = {1'b0, rem_q[k]} -
				({{(SUM_W+1-NORM_W){1'b0}}, dvs_q[k]} << SH);
			fits = !trial[SUM_W] && (dvs_q[k] != '0);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s <= 1'b0;
			end else if (advance) begin
				vld_s <= vld_q[k];
			end
		end
		always_ff @(posedge clk) begin
			if (advance) begin
				rem_s <= fits ? trial[SUM_W-1:0] : rem_q[k];
				dvs_s <= dvs_q[k];
				quo_s <= quo_q[k] | (fits ? (QUO_W'(1) << SH) : '0);
				tag_s <= tag_q[k];
			end
		end
		always_comb begin
			vld_q[k+1] = vld_s;
			rem_q[k+1] = rem_s;
			dvs_q[k+1] = dvs_s;
			quo_q[k+1] = quo_s;
			tag_q[k+1] = tag_s;
		end
	end

	assign out_valid = vld_q[QUO_W];
	assign quotient  = quo_q[QUO_W];
	assign out_tag   = tag_q[QUO_W];

endmodule

/* hw/rtl/normalized_window_convolution.sv */
//------------------------------------------------------------------------------
// normalized_window_convolution
// 3x3 signed convolution over a raster pixel stream, normalized by the
// larger of the positive and negative coefficient sums.
//------------------------------------------------------------------------------
// One pixel request is taken per clock while the result side does not stall.
// Two line memories with a registered read give the pixels of the two rows
// above; the pixel is registered while its column is read, then the window
// shifts, nine products are summed over two registered stages and an
// eight-stage divider pipeline resolves one quotient bit per stage. Stall on
// the result side freezes the whole pipeline. Writes to the same column on
// back-to-back pixels are forwarded around the memory read.
//------------------------------------------------------------------------------
module normalized_window_convolution
	import nwc_pkg::*;
#(
	parameter int MAX_LINE_WIDTH = 4096,
	parameter int COEF_BITS      = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [IDX_W-1:0]  cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PIX_W-1:0]  pixel_value,
	input  logic              frame_start,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PIX_W-1:0]  result_pixel,
	output logic [POS_W-1:0]  out_row,
	output logic [POS_W-1:0]  out_col,
	output logic              last_of_frame
);

	localparam int ADDR_W = $clog2(MAX_LINE_WIDTH);

	logic [GEOM_W-1:0] line_width_q, frame_height_q;
	logic [CFG_W-1:0]  coef_q [3];
	logic [NORM_W-1:0] norm_q;
	logic              norm_dirty_q;

	logic [POS_W:0]    wid, hgt;
	logic [POS_W-1:0]  col_q, row_q;
	logic              adv;

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	always_comb begin
		if (line_width_q < GEOM_W'(3))                   wid = 13'd3;
		else if (line_width_q > GEOM_W'(MAX_LINE_WIDTH)) wid = GEOM_W'(MAX_LINE_WIDTH);
		else                                              wid = line_width_q;
		if (frame_height_q < GEOM_W'(3))       hgt = 13'd3;
		else if (frame_height_q > 13'd4096)    hgt = 13'd4096;
		else                                    hgt = frame_height_q;
	end

	function automatic logic signed [COEF_BITS-1:0] coef(input logic [CFG_W-1:0] rowv,
		input int k);
		coef = rowv[k*COEF_BITS +: COEF_BITS];
	endfunction

	// Normalizer is refreshed the cycle after a coefficient write.
	logic [NORM_W-1:0] pos_sum, neg_sum;
	always_comb begin
		pos_sum = '0;
		neg_sum = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (coef(coef_q[i], j) > 0)
					pos_sum = pos_sum + NORM_W'(coef(coef_q[i], j));
				else
					neg_sum = neg_sum - NORM_W'(signed'(coef(coef_q[i], j)));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= 13'd640;
			frame_height_q <= 13'd480;
			coef_q[0]      <= '0;
			coef_q[1]      <= '0;
			coef_q[2]      <= '0;
			norm_q         <= '0;
			norm_dirty_q   <= 1'b0;
		end else begin
			norm_dirty_q <= cfg_we
				&& (cfg_index inside {REG_COEF_TOP, REG_COEF_MIDDLE, REG_COEF_BOTTOM});
			if (norm_dirty_q)
				norm_q <= (pos_sum > neg_sum) ? pos_sum : neg_sum;
			if (cfg_we) begin
				case (cfg_index)
					REG_LINE_WIDTH:   line_width_q   <= cfg_data[GEOM_W-1:0];
					REG_FRAME_HEIGHT: frame_height_q <= cfg_data[GEOM_W-1:0];
					REG_COEF_TOP:     coef_q[0]      <= cfg_data;
					REG_COEF_MIDDLE:  coef_q[1]      <= cfg_data;
					REG_COEF_BOTTOM:  coef_q[2]      <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Stage 1: position, memory read issue.
	logic              acc_in;
	logic [POS_W-1:0]  r_cur, c_cur;
	logic [POS_W:0]    c_nxt, r_nxt;
	assign acc_in = in_valid && adv;
	assign r_cur  = frame_start ? '0 : row_q;
	assign c_cur  = frame_start ? '0 : col_q;

	always_comb begin
		c_nxt = {1'b0, c_cur} + 13'd1;
		r_nxt = {1'b0, r_cur};
		if (c_nxt >= wid) begin
			c_nxt = '0;
			r_nxt = r_nxt + 13'd1;
			if (r_nxt >= hgt) r_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc_in) begin
			col_q <= c_nxt[POS_W-1:0];
			row_q <= r_nxt[POS_W-1:0];
		end
	end

	logic [PIX_W-1:0] mem_up [MAX_LINE_WIDTH];
	logic [PIX_W-1:0] mem_lo [MAX_LINE_WIDTH];
	logic [PIX_W-1:0] rd_up, rd_lo;
	logic              vld_s1, inmem_s1, emit_s1;
	logic [PIX_W-1:0]  pix_s1;
	logic [ADDR_W-1:0] addr_s1;
	res_tag_t          tag_s1;
	logic              fwd_s1;
	logic [PIX_W-1:0]  fwd_up_s1, fwd_lo_s1;
	logic [PIX_W-1:0]  up_s1, lo_s1;
	logic              inmem;
	assign inmem = {1'b0, c_cur} < (POS_W+1)'(MAX_LINE_WIDTH);

	always_ff @(posedge clk) begin
		if (acc_in) begin
			rd_up <= mem_up[c_cur[ADDR_W-1:0]];
			rd_lo <= mem_lo[c_cur[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= acc_in;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			pix_s1   <= pixel_value;
			addr_s1  <= c_cur[ADDR_W-1:0];
			inmem_s1 <= inmem;
			emit_s1  <= r_cur >= 12'd2 && {1'b0, r_cur} < hgt && c_cur >= 12'd2
				&& {1'b0, c_cur} < wid;
			tag_s1.last <= {1'b0, r_cur} == hgt - 13'd1 && {1'b0, c_cur} == wid - 13'd1;
			tag_s1.row  <= r_cur - 12'd1;
			tag_s1.col  <= c_cur - 12'd1;
			// A frame start right after a pixel in column zero reads the column
			// that is being written at the same edge; take the new data instead.
			fwd_s1    <= vld_s1 && inmem_s1 && inmem && addr_s1 == c_cur[ADDR_W-1:0];
			fwd_up_s1 <= lo_s1;
			fwd_lo_s1 <= pix_s1;
		end
	end

	assign up_s1 = fwd_s1 ? fwd_up_s1 : rd_up;
	assign lo_s1 = fwd_s1 ? fwd_lo_s1 : rd_lo;

	logic [PIX_W-1:0] win_q [9];
	always_ff @(posedge clk) begin
		if (vld_s1 && adv && inmem_s1) begin
			mem_up[addr_s1] <= lo_s1;
			mem_lo[addr_s1] <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else if (vld_s1 && adv) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i*3]   <= win_q[i*3+1];
				win_q[i*3+1] <= win_q[i*3+2];
			end
			win_q[2] <= inmem_s1 ? up_s1 : '0;
			win_q[5] <= inmem_s1 ? lo_s1 : '0;
			win_q[8] <= pix_s1;
		end
	end

	logic vld_s2;
	res_tag_t tag_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else if (adv) vld_s2 <= vld_s1 && emit_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) tag_s2 <= tag_s1;
	end

	// Stage 3: one partial sum per row.
	logic signed [SUM_W:0] rsum [3];
	logic signed [SUM_W:0] rsum_s3 [3];
	logic vld_s3;
	res_tag_t tag_s3;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			rsum[i] = '0;
			for (int j = 0; j < 3; j++)
				rsum[i] = rsum[i] + (SUM_W+1)'(signed'({1'b0, win_q[i*3+j]})
					* coef(coef_q[i], j));
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else if (adv) vld_s3 <= vld_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) rsum_s3[i] <= rsum[i];
			tag_s3 <= tag_s2;
		end
	end

	logic signed [SUM_W:0] tot;
	logic [SUM_W-1:0]      mag_s4;
	logic vld_s4;
	res_tag_t tag_s4;
	assign tot = rsum_s3[0] + rsum_s3[1] + rsum_s3[2];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else if (adv) vld_s4 <= vld_s3;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s4 <= tot[SUM_W] ? SUM_W'(-tot) : tot[SUM_W-1:0];
			tag_s4 <= tag_s3;
		end
	end

	res_tag_t otag;
	nwc_divider u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.dividend  (mag_s4),
		.divisor   (norm_q),
		.in_tag    (tag_s4),
		.advance   (adv),
		.out_valid (out_valid),
		.quotient  (result_pixel),
		.out_tag   (otag)
	);
	assign out_row       = otag.row;
	assign out_col       = otag.col;
	assign last_of_frame = otag.last;

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_pixel))
		else $error("result changed under stall");
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		acc_in |=> {1'b0, col_q} < $past(wid))
		else $error("column counter beyond width");
	a_emit_inner: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> tag_s2.row != 12'hfff && tag_s2.col != 12'hfff)
		else $error("border result emitted");
`endif

endmodule
